// File: hdl/ssmp_pkg.sv
// ----------------------------------------------------------------------------
// ssmp_pkg
// Shared constants and types of the specular sphere-map pixel core.
// ----------------------------------------------------------------------------
package ssmp_pkg;

    // Map geometry: a square map of 128 x 128 pixels (a power of two)
    localparam int IMAGE_SIZE = 128;
    localparam int N_SQ       = IMAGE_SIZE * IMAGE_SIZE;
    localparam int MAX_LIGHTS = 2;

    // Port widths
    localparam int PIX_W      = 7;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    // Square root units: 30-bit radicand, 15-bit root, one root bit per stage
    localparam int RAD_W       = 30;
    localparam int ROOT_W      = 15;
    localparam int SQRT_STEPS  = 15;

    // Repeated squarings of the Gaussian series
    localparam int SQUARINGS   = 10;

    // Reciprocal of six, exact for values below 4096
    localparam logic [13:0] RECIP6 = 14'd10923;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_COUNT    = 4'd0,
        REG_LIGHT0_DIR     = 4'd1,
        REG_LIGHT0_COL     = 4'd2,
        REG_LIGHT1_DIR     = 4'd3,
        REG_LIGHT1_COL     = 4'd4,
        REG_INV_VARIANCE   = 4'd5,
        REG_FRESNEL_EDGE   = 4'd6,
        REG_FRESNEL_CENTRE = 4'd7
    } cfg_reg_t;

    // Register reset values
    localparam logic [1:0]  LIGHT_COUNT_RST = 2'd1;
    localparam logic [47:0] LIGHT0_DIR_RST  = 48'h2000_0000_0000;
    localparam logic [47:0] LIGHT0_COL_RST  = 48'h4000_4000_4000;
    localparam logic [15:0] INV_VAR_RST     = 16'd12800;
    localparam logic [15:0] FRESNEL_RST     = 16'd24576;

    // One item in the square root pipeline
    typedef struct packed {
        logic              sx;
        logic              sy;
        logic [PIX_W-1:0]  ax;
        logic [PIX_W-1:0]  ay;
        logic [14:0]       s;
        logic              in_disc;
        logic [RAD_W-1:0]  rem_w;
        logic [ROOT_W-1:0] root_w;
        logic [RAD_W-1:0]  rem_r;
        logic [ROOT_W-1:0] root_r;
    } sqrt_t;

    // Per-pixel values that ride along the lighting stages
    typedef struct packed {
        logic        in_disc;
        logic [15:0] fres;
    } side_t;

endpackage

// File: hdl/ssmp_if.sv
// ----------------------------------------------------------------------------
// ssmp_if
// Handshake channels of the sphere-map pixel core: pixel in, color out,
// configuration write.
// ----------------------------------------------------------------------------
interface ssmp_pix_in_if;
    logic                       valid;
    logic                       ready;
    logic [ssmp_pkg::PIX_W-1:0] pixel_x;
    logic [ssmp_pkg::PIX_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ssmp_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic [ssmp_pkg::CH_W-1:0] red;
    logic [ssmp_pkg::CH_W-1:0] green;
    logic [ssmp_pkg::CH_W-1:0] blue;
    logic [ssmp_pkg::CH_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue,
                    output alpha, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha, output ready);
endinterface

interface ssmp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ssmp_pkg::CFG_IDX_W-1:0]  index;
    logic [ssmp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/specular_sphere_map_pixel_core.sv
// ----------------------------------------------------------------------------
// specular_sphere_map_pixel_core
// Pipelined generator of one RGBA8 sphere-map pixel per cycle (while no
// output stall is held) under Gaussian specular lights with a Fresnel blend.
// ----------------------------------------------------------------------------
// Usage:
//  pix_in  : one item is a (pixel_x, pixel_y) coordinate of the 128x128 map.
//  pix_out : one item is the red, green, blue, alpha color of that pixel,
//            in the order the coordinates were taken.
//  cfg     : register writes (index, data); always ready, write only while
//            no pixel is in flight.
//  Rate    : one pixel per cycle while the skid register is empty; every
//            stage holds one pixel, and the 36-stage pipeline (two bit-serial
//            square roots, ten squaring multipliers of the Gaussian) moves as one.
//  Stall   : when pix_out is not taken, a one-item skid register captures the
//            waiting result as the pipeline advances past it; pix_in
//            ready then drops until the skid item is taken.
//  Reset   : rst_n clears all valid bits and loads the register defaults:
//            one light along +z with unit color, falloff 50, Fresnel 1.5.
// ----------------------------------------------------------------------------
module specular_sphere_map_pixel_core (
    input  logic           clk,
    input  logic           rst_n,
    ssmp_cfg_if.sink       cfg,
    ssmp_pix_in_if.sink    pix_in,
    ssmp_pix_out_if.source pix_out
);
    import ssmp_pkg::*;

    // Stage numbering
    localparam int ST_F   = SQRT_STEPS + 1;
    localparam int ST_D   = ST_F + 1;
    localparam int ST_A   = ST_D + 1;
    localparam int ST_P1  = ST_A + 1;
    localparam int ST_P2  = ST_P1 + 1;
    localparam int ST_P3  = ST_P2 + 1;
    localparam int ST_Q0  = ST_P3 + 1;
    localparam int ST_G   = ST_Q0 + SQUARINGS;
    localparam int ST_H   = ST_G + 1;
    localparam int ST_T   = ST_H + 1;
    localparam int ST_OUT = ST_T + 1;
    localparam int NUM_ST = ST_OUT + 1;
    localparam int SIDE_N = ST_T - ST_F + 1;

    // Configuration registers
    logic [1:0]  light_count_reg;
    logic [47:0] light_dir_reg [MAX_LIGHTS];
    logic [47:0] light_col_reg [MAX_LIGHTS];
    logic [15:0] inv_variance_reg;
    logic [15:0] fresnel_edge_reg;
    logic [15:0] fresnel_centre_reg;

    // Pipeline control
    logic [NUM_ST-1:0] vld_reg;
    logic              skid_vld_reg;
    logic              en;

    // Pipeline payload
    sqrt_t              sq_reg  [SQRT_STEPS+1];
    sqrt_t              sq_next [SQRT_STEPS+1];
    side_t              side_reg [SIDE_N];
    side_t              side_next;
    logic signed [15:0] r_reg  [3];
    logic signed [15:0] r_next [3];
    logic [33:0]        d2_reg  [MAX_LIGHTS];
    logic [33:0]        d2_next [MAX_LIGHTS];
    logic               a_big_reg  [MAX_LIGHTS];
    logic               a_big_next [MAX_LIGHTS];
    logic [19:0]        a_reg  [MAX_LIGHTS];
    logic [19:0]        a_next [MAX_LIGHTS];
    logic               p1_big_reg [MAX_LIGHTS];
    logic [23:0]        p1_u_reg   [MAX_LIGHTS];
    logic [17:0]        p1_u2_reg  [MAX_LIGHTS];
    logic [17:0]        p1_u2_next [MAX_LIGHTS];
    logic               p2_big_reg [MAX_LIGHTS];
    logic [23:0]        p2_u_reg   [MAX_LIGHTS];
    logic [17:0]        p2_u2_reg  [MAX_LIGHTS];
    logic [11:0]        p2_u3_reg  [MAX_LIGHTS];
    logic [11:0]        p2_u3_next [MAX_LIGHTS];
    logic [30:0]        y_reg  [MAX_LIGHTS];
    logic [30:0]        y_next [MAX_LIGHTS];
    logic [30:0]        qy_reg  [SQUARINGS][MAX_LIGHTS];
    logic [30:0]        qy_next [SQUARINGS][MAX_LIGHTS];
    logic [32:0]        cg_reg  [MAX_LIGHTS][3];
    logic [32:0]        cg_next [MAX_LIGHTS][3];
    logic [48:0]        cgf_reg  [MAX_LIGHTS][3];
    logic [48:0]        cgf_next [MAX_LIGHTS][3];
    logic [56:0]        term_reg  [MAX_LIGHTS][3];
    logic [56:0]        term_next [MAX_LIGHTS][3];
    logic [CH_W-1:0]    rgb_reg  [3];
    logic [CH_W-1:0]    rgb_next [3];
    logic [CH_W-1:0]    alpha_reg;
    logic [CH_W-1:0]    alpha_next;
    logic [CH_W-1:0]    skid_rgb_reg [3];
    logic [CH_W-1:0]    skid_alpha_reg;

    // One bit of both square roots: try the next root bit, keep it if it fits
    function automatic sqrt_t sqrt_step(input sqrt_t a, input int k);
        sqrt_t       b;
        logic [31:0] tw;
        logic [31:0] tr;
        b  = a;
        tw = ({17'b0, a.root_w} << (k + 1)) + (32'd1 << (2 * k));
        tr = ({17'b0, a.root_r} << (k + 1)) + (32'd1 << (2 * k));
        if ({2'b0, a.rem_w} >= tw) begin
            b.rem_w  = a.rem_w - tw[RAD_W-1:0];
            b.root_w = a.root_w | (15'd1 << k);
        end
        if ({2'b0, a.rem_r} >= tr) begin
            b.rem_r  = a.rem_r - tr[RAD_W-1:0];
            b.root_r = a.root_r | (15'd1 << k);
        end
        return b;
    endfunction

    // Write configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_count_reg    <= LIGHT_COUNT_RST;
            light_dir_reg[0]   <= LIGHT0_DIR_RST;
            light_col_reg[0]   <= LIGHT0_COL_RST;
            light_dir_reg[1]   <= '0;
            light_col_reg[1]   <= '0;
            inv_variance_reg   <= INV_VAR_RST;
            fresnel_edge_reg   <= FRESNEL_RST;
            fresnel_centre_reg <= FRESNEL_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_LIGHT_COUNT:    light_count_reg    <= cfg.data[1:0];
                REG_LIGHT0_DIR:     light_dir_reg[0]   <= cfg.data;
                REG_LIGHT0_COL:     light_col_reg[0]   <= cfg.data;
                REG_LIGHT1_DIR:     light_dir_reg[1]   <= cfg.data;
                REG_LIGHT1_COL:     light_col_reg[1]   <= cfg.data;
                REG_INV_VARIANCE:   inv_variance_reg   <= cfg.data[15:0];
                REG_FRESNEL_EDGE:   fresnel_edge_reg   <= cfg.data[15:0];
                REG_FRESNEL_CENTRE: fresnel_centre_reg <= cfg.data[15:0];
                default:            ;
            endcase
        end
    end

    // Advance the whole pipeline unless the skid register is full
    assign en           = !skid_vld_reg;
    assign pix_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NUM_ST-2:0], pix_in.valid};
    end

    // Center the coordinate, test the disc and seed both square roots
    logic signed [8:0] ix_w;
    logic signed [8:0] iy_w;
    logic [8:0]        ax_full;
    logic [8:0]        ay_full;
    logic [13:0]       ax2;
    logic [13:0]       ay2;
    logic [14:0]       s_w;
    logic              inside_w;

    assign ix_w     = $signed({1'b0, pix_in.pixel_x, 1'b0}) - 9'sd127;
    assign iy_w     = $signed({1'b0, pix_in.pixel_y, 1'b0}) - 9'sd127;
    assign ax_full  = ix_w[8] ? 9'(-ix_w) : 9'(ix_w);
    assign ay_full  = iy_w[8] ? 9'(-iy_w) : 9'(iy_w);
    assign ax2      = ax_full[6:0] * ax_full[6:0];
    assign ay2      = ay_full[6:0] * ay_full[6:0];
    assign s_w      = {1'b0, ax2} + {1'b0, ay2};
    assign inside_w = s_w <= 15'(N_SQ);

    always_comb
    begin
        sq_next[0].sx      = ix_w[8];
        sq_next[0].sy      = iy_w[8];
        sq_next[0].ax      = ax_full[6:0];
        sq_next[0].ay      = ay_full[6:0];
        sq_next[0].s       = s_w;
        sq_next[0].in_disc = inside_w;
        sq_next[0].rem_w   = inside_w ? {3'b0, 15'(N_SQ) - s_w, 12'b0} : '0;
        sq_next[0].root_w  = '0;
        sq_next[0].rem_r   = {1'b0, s_w, 14'b0};
        sq_next[0].root_r  = '0;
        for (int j = 1; j <= SQRT_STEPS; j++)
            sq_next[j] = sqrt_step(sq_reg[j-1], SQRT_STEPS - j);
    end

    // Reflection vector and Fresnel factor
    logic [21:0] pw_x;
    logic [21:0] pw_y;
    logic [21:0] rw_x;
    logic [21:0] rw_y;
    logic [15:0] s_inc;
    logic [14:0] cw;
    logic [31:0] fres_sum;

    always_comb
    begin
        pw_x      = sq_reg[SQRT_STEPS].root_w * sq_reg[SQRT_STEPS].ax;
        pw_y      = sq_reg[SQRT_STEPS].root_w * sq_reg[SQRT_STEPS].ay;
        rw_x      = pw_x + 22'd32;
        rw_y      = pw_y + 22'd32;
        r_next[0] = sq_reg[SQRT_STEPS].sx ? -$signed({1'b0, rw_x[20:6]})
                                          : $signed({1'b0, rw_x[20:6]});
        r_next[1] = sq_reg[SQRT_STEPS].sy ? -$signed({1'b0, rw_y[20:6]})
                                          : $signed({1'b0, rw_y[20:6]});
        s_inc     = {1'b0, sq_reg[SQRT_STEPS].s} + 16'd1;
        r_next[2] = 16'sd8192 - $signed({s_inc[15:1], 1'b0});
        cw        = 15'(N_SQ) - sq_reg[SQRT_STEPS].root_r;
        fres_sum  = 32'(cw) * 32'(fresnel_centre_reg)
                  + 32'(sq_reg[SQRT_STEPS].root_r) * 32'(fresnel_edge_reg);
        side_next.in_disc = sq_reg[SQRT_STEPS].in_disc;
        side_next.fres    = fres_sum[29:14];
    end

    // Distance to each light, falloff exponent and the series terms
    logic signed [16:0] dv;
    logic signed [33:0] dsq;
    logic [49:0]        prod_a;
    logic [47:0]        uu;
    logic [41:0]        uuu;
    logic [25:0]        q6;
    logic [31:0]        y_sum;

    always_comb
    begin
        for (int l = 0; l < MAX_LIGHTS; l++)
        begin
            d2_next[l] = '0;
            for (int c = 0; c < 3; c++)
            begin
                dv  = 17'(r_reg[c]) - 17'($signed(light_dir_reg[l][16*c +: 16]));
                dsq = dv * dv;
                d2_next[l] = d2_next[l] + {2'b0, dsq[31:0]};
            end
            prod_a        = d2_reg[l] * inv_variance_reg;
            a_big_next[l] = |prod_a[49:38];
            a_next[l]     = prod_a[37:18];
            uu            = {a_reg[l], 4'b0} * {a_reg[l], 4'b0};
            p1_u2_next[l] = uu[47:30];
            uuu           = p1_u2_reg[l] * p1_u_reg[l];
            p2_u3_next[l] = uuu[41:30];
            q6            = p2_u3_reg[l] * RECIP6;
            y_sum         = 32'h4000_0000 - {8'b0, p2_u_reg[l]}
                          + {15'b0, p2_u2_reg[l][17:1]} - {22'b0, q6[25:16]};
            y_next[l]     = p2_big_reg[l] ? '0 : y_sum[30:0];
        end
    end

    // Ten squarings of the series value
    logic [61:0] ysq;

    always_comb
    begin
        for (int l = 0; l < MAX_LIGHTS; l++)
        begin
            ysq = y_reg[l] * y_reg[l];
            ysq = ysq + (62'd1 << 29);
            qy_next[0][l] = ysq[60:30];
        end
        for (int q = 1; q < SQUARINGS; q++)
        begin
            for (int l = 0; l < MAX_LIGHTS; l++)
            begin
                ysq = qy_reg[q-1][l] * qy_reg[q-1][l];
                ysq = ysq + (62'd1 << 29);
                qy_next[q][l] = ysq[60:30];
            end
        end
    end

    // Weight by light color, Fresnel factor and full scale
    always_comb
    begin
        for (int l = 0; l < MAX_LIGHTS; l++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cg_next[l][c]   = light_col_reg[l][16*c +: 16]
                                * qy_reg[SQUARINGS-1][l][30:14];
                cgf_next[l][c]  = cg_reg[l][c] * side_reg[ST_G-ST_F].fres;
                term_next[l][c] = (light_count_reg > 2'(l))
                                ? ({cgf_reg[l][c], 8'b0} - {8'b0, cgf_reg[l][c]})
                                : '0;
            end
        end
    end

    // Sum the lights, clamp each channel, black outside the disc
    logic [57:0] ch_sum;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ch_sum = '0;
            for (int l = 0; l < MAX_LIGHTS; l++)
                ch_sum = ch_sum + {1'b0, term_reg[l][c]};
            if (!side_reg[SIDE_N-1].in_disc)
                rgb_next[c] = '0;
            else if (|ch_sum[57:52])
                rgb_next[c] = 8'hFF;
            else
                rgb_next[c] = ch_sum[51:44];
        end
        alpha_next = side_reg[SIDE_N-1].in_disc ? 8'hFF : 8'h01;
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j <= SQRT_STEPS; j++)
                sq_reg[j] <= sq_next[j];
            side_reg[0] <= side_next;
            for (int j = 1; j < SIDE_N; j++)
                side_reg[j] <= side_reg[j-1];
            for (int c = 0; c < 3; c++)
                r_reg[c] <= r_next[c];
            for (int l = 0; l < MAX_LIGHTS; l++)
            begin
                d2_reg[l]     <= d2_next[l];
                a_big_reg[l]  <= a_big_next[l];
                a_reg[l]      <= a_next[l];
                p1_big_reg[l] <= a_big_reg[l];
                p1_u_reg[l]   <= {a_reg[l], 4'b0};
                p1_u2_reg[l]  <= p1_u2_next[l];
                p2_big_reg[l] <= p1_big_reg[l];
                p2_u_reg[l]   <= p1_u_reg[l];
                p2_u2_reg[l]  <= p1_u2_reg[l];
                p2_u3_reg[l]  <= p2_u3_next[l];
                y_reg[l]      <= y_next[l];
                for (int q = 0; q < SQUARINGS; q++)
                    qy_reg[q][l] <= qy_next[q][l];
                for (int c = 0; c < 3; c++)
                begin
                    cg_reg[l][c]   <= cg_next[l][c];
                    cgf_reg[l][c]  <= cgf_next[l][c];
                    term_reg[l][c] <= term_next[l][c];
                end
            end
            for (int c = 0; c < 3; c++)
                rgb_reg[c] <= rgb_next[c];
            alpha_reg <= alpha_next;
        end
    end

    // Hold a waiting result in the skid register while the pipeline steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_vld_reg <= 1'b0;
        else if (skid_vld_reg)
        begin
            if (pix_out.ready)
                skid_vld_reg <= 1'b0;
        end
        else if (vld_reg[ST_OUT] && !pix_out.ready)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_vld_reg)
        begin
            for (int c = 0; c < 3; c++)
                skid_rgb_reg[c] <= rgb_reg[c];
            skid_alpha_reg <= alpha_reg;
        end
    end

    // Drive the output channel
    assign pix_out.valid = skid_vld_reg || vld_reg[ST_OUT];
    assign pix_out.red   = skid_vld_reg ? skid_rgb_reg[0] : rgb_reg[0];
    assign pix_out.green = skid_vld_reg ? skid_rgb_reg[1] : rgb_reg[1];
    assign pix_out.blue  = skid_vld_reg ? skid_rgb_reg[2] : rgb_reg[2];
    assign pix_out.alpha = skid_vld_reg ? skid_alpha_reg : alpha_reg;

endmodule

// File: tb/sv/specular_sphere_map_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// specular_sphere_map_pixel_checker
// Watches the configuration, pixel and color channels of the sphere-map
// pixel core. It mirrors the configuration registers, computes the expected color
// of each accepted pixel and compares every accepted color with the oldest
// expected one.
// ----------------------------------------------------------------------------
module specular_sphere_map_pixel_checker (
    input  logic     clk,
    input  logic     rst_n,
    ssmp_cfg_if      cfg,
    ssmp_pix_in_if   pix_in,
    ssmp_pix_out_if  pix_out,
    output int       errors,
    output int       pending
);
    import ssmp_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } color_t;

    logic [1:0]  lights_used;
    logic [47:0] dir_reg [2];
    logic [47:0] col_reg [2];
    logic [15:0] inv_var;
    logic [15:0] fres_edge;
    logic [15:0] fres_centre;
    color_t      color_q[$];

    // Exact floor square root, one result bit per step
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 50;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Gaussian falloff exp(-a) in Q.16 by a cubic series and ten squarings
    function automatic longint unsigned falloff(longint unsigned a);
        longint unsigned u, u2, u3, acc;
        if (a >= (64'd16 << 16))
            return 0;
        u   = a * 16;
        u2  = (u * u) >> 30;
        u3  = (u2 * u) >> 30;
        acc = (64'd1 << 30) - u + (u2 >> 1) - u3 / 6;
        for (int i = 0; i < SQUARINGS; i++)
            acc = (acc * acc + (64'd1 << 29)) >> 30;
        return acc >> 14;
    endfunction

    // Centered, normalized coordinate in Q2.13, rounded half away from zero
    function automatic longint norm_coord(longint c);
        longint unsigned mag;
        mag = ((c < 0 ? -c : c) * 8192 + IMAGE_SIZE / 2) / IMAGE_SIZE;
        return c < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic color_t shade_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        longint          ix, iy, x, y, d, m;
        longint          refl [3];
        longint unsigned s, sq, w, sr, fres, d2, g, nl, colv;
        longint unsigned sum [3];
        color_t          res;
        ix = 2 * longint'(px) - (IMAGE_SIZE - 1);
        iy = 2 * longint'(py) - (IMAGE_SIZE - 1);
        s  = ix * ix + iy * iy;
        res = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd1};
        if (s > N_SQ)
            return res;
        x  = norm_coord(ix);
        y  = norm_coord(iy);
        sq = (s * 8192 + N_SQ / 2) / N_SQ;
        w  = floor_sqrt(((N_SQ - s) << 26) / N_SQ);
        sr = floor_sqrt((s << 28) / N_SQ);
        // 2w is never negative, so the sign follows the coordinate
        m = ((2 * w * (x < 0 ? -x : x)) + 4096) >> 13;
        refl[0] = x < 0 ? -m : m;
        m = ((2 * w * (y < 0 ? -y : y)) + 4096) >> 13;
        refl[1] = y < 0 ? -m : m;
        refl[2] = 8192 - 2 * longint'(sq);
        fres = ((16384 - sr) * fres_centre + sr * fres_edge) >> 14;
        nl = lights_used < MAX_LIGHTS ? lights_used : MAX_LIGHTS;
        sum = '{0, 0, 0};
        for (int l = 0; l < nl; l++)
        begin
            d2 = 0;
            for (int c = 0; c < 3; c++)
            begin
                d  = refl[c] - longint'($signed(dir_reg[l][16*c +: 16]));
                d2 = d2 + d * d;
            end
            g = falloff((d2 * inv_var) >> 18);
            for (int c = 0; c < 3; c++)
            begin
                colv   = col_reg[l][16*c +: 16];
                sum[c] = sum[c] + colv * g * fres * 255;
            end
        end
        res.red   = (sum[0] >> 44) > 255 ? 8'd255 : 8'((sum[0] >> 44));
        res.green = (sum[1] >> 44) > 255 ? 8'd255 : 8'((sum[1] >> 44));
        res.blue  = (sum[2] >> 44) > 255 ? 8'd255 : 8'((sum[2] >> 44));
        res.alpha = 8'd255;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Mirror register writes, predict accepted pixels, compare accepted colors
    always @(posedge clk or negedge rst_n)
    begin
        color_t want;
        if (!rst_n)
        begin
            errors       = 0;
            pending     <= 0;
            lights_used <= LIGHT_COUNT_RST;
            dir_reg[0]  <= LIGHT0_DIR_RST;
            col_reg[0]  <= LIGHT0_COL_RST;
            dir_reg[1]  <= '0;
            col_reg[1]  <= '0;
            inv_var     <= INV_VAR_RST;
            fres_edge   <= FRESNEL_RST;
            fres_centre <= FRESNEL_RST;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_LIGHT_COUNT:    lights_used <= cfg.data[1:0];
                    REG_LIGHT0_DIR:     dir_reg[0]  <= cfg.data;
                    REG_LIGHT0_COL:     col_reg[0]  <= cfg.data;
                    REG_LIGHT1_DIR:     dir_reg[1]  <= cfg.data;
                    REG_LIGHT1_COL:     col_reg[1]  <= cfg.data;
                    REG_INV_VARIANCE:   inv_var     <= cfg.data[15:0];
                    REG_FRESNEL_EDGE:   fres_edge   <= cfg.data[15:0];
                    REG_FRESNEL_CENTRE: fres_centre <= cfg.data[15:0];
                    default: ;
                endcase
            end
            if (pix_in.valid && pix_in.ready)
                color_q.push_back(shade_pixel(pix_in.pixel_x, pix_in.pixel_y));
            if (pix_out.valid && pix_out.ready)
            begin
                if (color_q.size() == 0)
                    report_mismatch("pixels waiting for a color", 0, 1);
                else
                begin
                    want = color_q.pop_front();
                    if (pix_out.red !== want.red)
                        report_mismatch("red", pix_out.red, want.red);
                    if (pix_out.green !== want.green)
                        report_mismatch("green", pix_out.green, want.green);
                    if (pix_out.blue !== want.blue)
                        report_mismatch("blue", pix_out.blue, want.blue);
                    if (pix_out.alpha !== want.alpha)
                        report_mismatch("alpha", pix_out.alpha, want.alpha);
                end
            end
            pending <= color_q.size();
        end
    end

endmodule

// File: tb/sv/specular_sphere_map_pixel_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// specular_sphere_map_pixel_core_tb
// Drives pixel coordinates and register settings into the sphere-map pixel
// core under random idling on both sides and one long output hold-off; the
// checker beside the block predicts and compares every color.
// ----------------------------------------------------------------------------
module specular_sphere_map_pixel_core_tb;
    import ssmp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd15;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   calm;
    bit   hold_req;
    bit   held = 1'b0;
    int   hold_left = 0;

    ssmp_cfg_if     cfg();
    ssmp_pix_in_if  pix_in();
    ssmp_pix_out_if pix_out();

    specular_sphere_map_pixel_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    specular_sphere_map_pixel_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("specular_sphere_map_pixel_core test failed");
            $finish;
        end
    end

    // Color receiver: random idling, one long hold-off while items pile up
    always @(posedge clk)
    begin
        if (hold_req && !held)
        begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left     = hold_left - 1;
            pix_out.ready <= 1'b0;
        end
        else if (calm)
            pix_out.ready <= 1'b1;
        else
            pix_out.ready <= ($urandom_range(99) >= 25);
    end

    task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        while (!calm && $urandom_range(99) < 25)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid   <= 1'b1;
        pix_in.pixel_x <= px;
        pix_in.pixel_y <= py;
        do
            @(posedge clk);
        while (!pix_in.ready);
    endtask

    // Wait for the pipeline to drain, then write one register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [47:0] rand_direction(bit wild);
        logic [47:0] v;
        for (int k = 0; k < 3; k++)
            v[16*k +: 16] = wild ? 16'($urandom) : 16'($urandom_range(16384) - 8192);
        return v;
    endfunction

    task automatic random_pixels(int count);
        repeat (count) send_pixel(7'($urandom), 7'($urandom));
    endtask

    initial
    begin
        calm           = 1'b0;
        hold_req       = 1'b0;
        rst_n          <= 1'b0;
        cfg.valid      <= 1'b0;
        cfg.index      <= '0;
        cfg.data       <= '0;
        pix_in.valid   <= 1'b0;
        pix_in.pixel_x <= '0;
        pix_in.pixel_y <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners, center, rim and beyond-rim pixels at reset settings
        send_pixel(7'd0, 7'd0);
        send_pixel(7'd127, 7'd127);
        send_pixel(7'd0, 7'd127);
        send_pixel(7'd127, 7'd0);
        send_pixel(7'd63, 7'd63);
        send_pixel(7'd64, 7'd64);
        send_pixel(7'd63, 7'd64);
        send_pixel(7'd0, 7'd63);
        send_pixel(7'd0, 7'd64);
        send_pixel(7'd63, 7'd0);
        send_pixel(7'd127, 7'd64);
        send_pixel(7'd85, 7'd42);
        send_pixel(7'd42, 7'd85);
        send_pixel(7'd1, 7'd1);
        random_pixels(200);

        // No light in use: inside pixels black
        write_reg(REG_LIGHT_COUNT, 48'd0);
        send_pixel(7'd64, 7'd63);
        send_pixel(7'd127, 7'd127);
        random_pixels(150);

        // Count above the maximum saturates; two lights, unused index ignored
        write_reg(REG_LIGHT_COUNT, 48'd3);
        write_reg(REG_LIGHT1_DIR, 48'h2000_0000_0000);
        write_reg(REG_LIGHT1_COL, 48'h4000_2000_1000);
        write_reg(CFG_IDX_UNUSED, 48'hFFFF_FFFF_FFFF);
        random_pixels(200);

        // Strong colors, long stretch with no idling and a long output hold-off
        write_reg(REG_LIGHT_COUNT, 48'd2);
        write_reg(REG_LIGHT0_COL, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_LIGHT1_COL, 48'h0000_0000_0000);
        write_reg(REG_LIGHT0_DIR, rand_direction(1'b0));
        calm     = 1'b1;
        hold_req = 1'b1;
        random_pixels(500);
        calm = 1'b0;

        // Extremes of falloff and Fresnel factors
        write_reg(REG_INV_VARIANCE, 48'd0);
        write_reg(REG_FRESNEL_EDGE, 48'hFFFF);
        write_reg(REG_FRESNEL_CENTRE, 48'd0);
        random_pixels(120);
        write_reg(REG_INV_VARIANCE, 48'hFFFF);
        write_reg(REG_FRESNEL_EDGE, 48'd0);
        write_reg(REG_FRESNEL_CENTRE, 48'hFFFF);
        write_reg(REG_LIGHT1_DIR, 48'h8000_8000_8000);
        random_pixels(120);

        // Random settings, mostly directions with each component in [-1, 1]
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_LIGHT_COUNT, 48'($urandom_range(3)));
            write_reg(REG_LIGHT0_DIR, rand_direction(ph == 5));
            write_reg(REG_LIGHT1_DIR, rand_direction(ph == 4));
            write_reg(REG_LIGHT0_COL, 48'({$urandom, $urandom}));
            write_reg(REG_LIGHT1_COL, 48'({$urandom, $urandom}));
            write_reg(REG_INV_VARIANCE, 48'($urandom_range(20000)));
            write_reg(REG_FRESNEL_EDGE, 48'($urandom_range(65535)));
            write_reg(REG_FRESNEL_CENTRE, 48'($urandom_range(65535)));
            random_pixels(110);
        end

        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("specular_sphere_map_pixel_core test passed");
        else
            $display("specular_sphere_map_pixel_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/ssmp_pkg.sv
hdl/ssmp_if.sv
hdl/specular_sphere_map_pixel_core.sv
tb/sv/specular_sphere_map_pixel_checker.sv
tb/sv/specular_sphere_map_pixel_core_tb.sv
